@@ hdl/osrb_pkg.sv @@
// shared types and constants for the overwriting sample ring buffer
// no dependencies; imported by osrb_store and the top level

package osrb_pkg;

  // audio sample and configuration widths
  localparam int SAMPLE_W = 16;
  localparam int CAP_W    = 13;
  localparam int POS_W    = 12;
  localparam int LEVEL_W  = 13;
  localparam int STAT_W   = 64;

  // reset value of the capacity register
  localparam int CAP_RESET = 4096;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // item operation codes
  typedef enum logic [1:0] {
    OP_APPEND     = 2'd0,
    OP_READ       = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_STAT_RESET = 2'd3
  } op_t;

endpackage

@@ hdl/osrb_store.sv @@
// single-port sample store with registered read
// depends on osrb_pkg for the sample type

module osrb_store #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  osrb_pkg::sample_t        wdata,
  output osrb_pkg::sample_t        rdata
);
  import osrb_pkg::*;

  sample_t mem [DEPTH];
  sample_t rdata_r;

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/overwriting_sample_ring_buffer.sv @@
// overwriting ring buffer of signed 16-bit samples; every input item returns one result
// an accepted item passes through the read stage register, then the output register
// throughput: one item per cycle unless out_tready stalls, set by the single-port sample store and its read stage
// reset (synchronous, rst_n low): pointer, fill and both counters zero, capacity 4096
// clamped to DEPTH; store contents are not cleared, reads only reach written entries
// depends on osrb_pkg and osrb_store

module overwriting_sample_ring_buffer #(
  parameter int DEPTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write: capacity
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [osrb_pkg::CAP_W-1:0] cfg_data,
  // input items
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,  // sample_in[15:0], read_position[27:16], zero pad
  input  logic [1:0]                in_tuser,  // operation[1:0]
  // result items
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [159:0]              out_tdata, // sample_out[15:0], fill_level[28:16],
                                               // is_full[29], is_empty[30],
                                               // total_written[94:31],
                                               // overwritten_count[158:95], zero pad
  output logic                      out_tuser  // read_valid[0]
);
  import osrb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int XW = (FW > CAP_W) ? FW : CAP_W;
  localparam int SW = ((FW > POS_W) ? FW : POS_W) + 1;
  localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  typedef struct packed {
    logic                read_valid;
    logic [LEVEL_W-1:0]  fill_level;
    logic                is_full;
    logic                is_empty;
    logic [STAT_W-1:0]   total_written;
    logic [STAT_W-1:0]   overwritten_count;
  } status_t;

  // architectural state
  logic [FW-1:0]     cap_r;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [STAT_W-1:0] total_r, total_nxt;
  logic [STAT_W-1:0] over_r, over_nxt;

  // pipeline registers
  logic    pend_valid_r;
  status_t pend_stat_r;
  status_t pend_stat_nxt;
  logic    out_valid_r;
  status_t out_stat_r;
  sample_t out_sample_r;

  // unpacked input fields
  op_t              op;
  sample_t          sample_in;
  logic [POS_W-1:0] read_position;

  assign op            = op_t'(in_tuser);
  assign sample_in     = sample_t'(in_tdata[15:0]);
  assign read_position = in_tdata[27:16];

  logic    advance;
  logic    accept;
  logic    cfg_fire;
  logic    mem_en;
  logic    mem_we;
  logic [AW-1:0] mem_addr;
  sample_t mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance || !pend_valid_r;
  assign accept    = in_tvalid && in_tready;

  // capacity clamp to the range 1 .. DEPTH
  logic [XW-1:0] cap_x;
  logic [FW-1:0] cap_clamped;
  always_comb begin
    cap_x = XW'(cfg_data);
    if (cap_x == '0) begin
      cap_x = XW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      cap_x = XW'(DEPTH);
    end
    cap_clamped = FW'(cap_x);
  end

  // next state and result status for the accepted item
  logic [FW-1:0] wp_inc;
  logic [AW-1:0] oldest;
  logic [SW-1:0] idx_sum;
  logic [SW-1:0] idx_wrap;
  logic          pos_ok;
  always_comb begin
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    over_nxt  = over_r;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = wp_r;

    wp_inc   = FW'(wp_r) + FW'(1);
    pos_ok   = SW'(read_position) < SW'(fill_r);
    oldest   = (fill_r == cap_r) ? wp_r : '0;
    idx_sum  = SW'(oldest) + SW'(read_position);
    idx_wrap = (idx_sum >= SW'(cap_r)) ? (idx_sum - SW'(cap_r)) : idx_sum;

    case (op)
      OP_APPEND: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        wp_nxt   = (wp_inc >= cap_r) ? '0 : AW'(wp_inc);
        if (fill_r < cap_r) begin
          fill_nxt = fill_r + FW'(1);
        end else begin
          over_nxt = over_r + STAT_W'(1);
        end
        total_nxt = total_r + STAT_W'(1);
      end
      OP_READ: begin
        mem_en   = pos_ok;
        mem_addr = AW'(idx_wrap);
      end
      OP_CLEAR: begin
        wp_nxt   = '0;
        fill_nxt = '0;
      end
      default: begin
        total_nxt = '0;
        over_nxt  = '0;
      end
    endcase

    pend_stat_nxt.read_valid        = (op == OP_READ) && pos_ok;
    pend_stat_nxt.fill_level        = LEVEL_W'(fill_nxt);
    pend_stat_nxt.is_full           = (fill_nxt == cap_r);
    pend_stat_nxt.is_empty          = (fill_nxt == '0);
    pend_stat_nxt.total_written     = total_nxt;
    pend_stat_nxt.overwritten_count = over_nxt;
  end

  osrb_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (accept && mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (sample_in),
    .rdata (mem_rdata)
  );

  // state registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= FW'(CAP_INIT);
      wp_r    <= '0;
      fill_r  <= '0;
      total_r <= '0;
      over_r  <= '0;
    end else if (cfg_fire) begin
      cap_r  <= cap_clamped;
      wp_r   <= '0;
      fill_r <= '0;
    end else if (accept) begin
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      over_r  <= over_nxt;
    end
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= pend_valid_r;
      end
      if (accept) begin
        pend_valid_r <= 1'b1;
      end else if (advance) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_stat_r <= pend_stat_nxt;
    end
    if (advance && pend_valid_r) begin
      out_stat_r   <= pend_stat_r;
      out_sample_r <= pend_stat_r.read_valid ? mem_rdata : '0;
    end
  end

  // result transaction packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r.read_valid;
  assign out_tdata  = {1'b0,
                       out_stat_r.overwritten_count,
                       out_stat_r.total_written,
                       out_stat_r.is_empty,
                       out_stat_r.is_full,
                       out_stat_r.fill_level,
                       out_sample_r};

endmodule
